/* design/lpa_pkg.sv */
package lpa_pkg;

  localparam int CFG_DATA_W  = 48;
  localparam int CFG_INDEX_W = 3;
  localparam int DELTA_W     = 32;
  localparam int FIELD_POS_W = 48;
  localparam int RATE_W      = 24;
  localparam int PROD_W      = DELTA_W + RATE_W;

  localparam logic signed [RATE_W-1:0] RATE_RESET = RATE_W'(65536);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TRACK_LOADED  = 3'd0,
    CFG_PLAYING       = 3'd1,
    CFG_PLAYBACK_RATE = 3'd2,
    CFG_LOOP_ENABLE   = 3'd3,
    CFG_LOOP_IN       = 3'd4,
    CFG_LOOP_OUT      = 3'd5
  } cfg_index_t;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_SEEK = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_WRAP,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                          kind;
    logic signed [DELTA_W-1:0]     delta_time;
    logic signed [FIELD_POS_W-1:0] seek_position;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_POS_W-1:0] position;
    logic                          advanced;
    logic                          wrapped;
    logic                          saturated;
  } out_item_t;

endpackage

/* design/loop_playhead_advance.sv */
// channel | handshake             | payload
// --------+-----------------------+------------------------------
// in      | in_valid / in_ready   | in_data  (lpa_pkg::in_item_t)
// out     | out_valid / out_ready | out_data (lpa_pkg::out_item_t)
// cfg     | cfg_we                | cfg_index, cfg_data
//
// A seek beat goes from ST_IDLE straight to ST_DONE; a tick without wrap passes ST_ADD and ST_WRAP.
// A tick that wraps runs a restoring remainder, one dividend bit per cycle, over
// WW-1 bits (57 at the default, 65 at POSITION_BITS = 64) in ST_DIV, then ST_FIN.
// in_ready is high only while the sequencer idles; the output register holds a
// result while out_ready is low and the next beat is still taken.
// rst_n is synchronous: it clears position, pending seek, configuration and handshakes.
module loop_playhead_advance #(
  parameter int POSITION_BITS      = 48,
  parameter int RATE_FRACTION_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  lpa_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output lpa_pkg::out_item_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [lpa_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [lpa_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int P      = POSITION_BITS;
  localparam int WW     = ((P > lpa_pkg::PROD_W) ? P : lpa_pkg::PROD_W) + 2;
  localparam int DVD_W  = WW - 1;
  localparam int LEN_W  = lpa_pkg::FIELD_POS_W;
  localparam int CNT_W  = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);
  localparam logic signed [WW-1:0] POS_MAX_W = {{(WW-P+1){1'b0}}, {(P-1){1'b1}}};
  localparam logic signed [WW-1:0] POS_MIN_W = ~POS_MAX_W;

  lpa_pkg::state_t state_r, state_nxt;

  logic                                    loaded_r, loaded_nxt;
  logic                                    playing_r, playing_nxt;
  logic signed [lpa_pkg::RATE_W-1:0]       rate_r, rate_nxt;
  logic                                    loop_en_r, loop_en_nxt;
  logic signed [lpa_pkg::FIELD_POS_W-1:0]  loop_in_r, loop_in_nxt;
  logic signed [lpa_pkg::FIELD_POS_W-1:0]  loop_out_r, loop_out_nxt;

  logic signed [P-1:0]                     pos_r, pos_nxt;
  logic                                    pend_r, pend_nxt;
  logic signed [P-1:0]                     pend_pos_r, pend_pos_nxt;

  logic signed [lpa_pkg::PROD_W-1:0]       prod_r, prod_nxt;
  logic signed [WW-1:0]                    acc_r, acc_nxt;
  logic                                    adv_r, adv_nxt;
  logic                                    wrap_r, wrap_nxt;
  logic                                    sat_r, sat_nxt;
  logic                                    neg_r, neg_nxt;
  logic [DVD_W-1:0]                        dvd_r, dvd_nxt;
  logic [LEN_W-1:0]                        len_r, len_nxt;
  logic [LEN_W-1:0]                        rem_r, rem_nxt;
  logic [CNT_W-1:0]                        cnt_r, cnt_nxt;

  logic                                    out_valid_r, out_valid_nxt;
  lpa_pkg::out_item_t                      out_data_r, out_data_nxt;

  logic                                    in_fire;
  logic                                    out_free;
  logic                                    tick_run;
  logic                                    wrap_fwd;
  logic                                    wrap_rev;
  logic signed [WW-1:0]                    seek_w;
  logic signed [WW-1:0]                    seek_clamp;
  logic signed [lpa_pkg::PROD_W-1:0]       prod_now;
  logic signed [WW-1:0]                    step_w;
  logic signed [WW-1:0]                    sum_w;
  logic signed [WW-1:0]                    lin_w;
  logic signed [WW-1:0]                    lout_w;
  logic signed [WW-1:0]                    diff_fwd;
  logic signed [WW-1:0]                    diff_rev;
  logic signed [WW-1:0]                    rem_w;
  logic signed [WW-1:0]                    fin_w;
  logic signed [WW-1:0]                    pos_w;
  logic [LEN_W:0]                          rem_shift;
  logic [LEN_W:0]                          rem_sub;

  assign in_ready  = (state_r == lpa_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign tick_run  = loaded_r && playing_r;

  assign seek_w     = WW'(in_data.seek_position);
  assign seek_clamp = (seek_w > POS_MAX_W) ? POS_MAX_W :
                      (seek_w < POS_MIN_W) ? POS_MIN_W : seek_w;
  assign prod_now   = lpa_pkg::PROD_W'(in_data.delta_time) * lpa_pkg::PROD_W'(rate_r);
  assign step_w     = WW'(prod_r) >>> RATE_FRACTION_BITS;
  assign sum_w      = WW'(pos_r) + step_w;
  assign lin_w      = WW'(loop_in_r);
  assign lout_w     = WW'(loop_out_r);
  assign diff_fwd   = acc_r - lout_w;
  assign diff_rev   = lin_w - acc_r;
  assign wrap_fwd   = loop_en_r && (lout_w > lin_w) && !rate_r[lpa_pkg::RATE_W-1] &&
                      (acc_r >= lout_w);
  assign wrap_rev   = loop_en_r && (lout_w > lin_w) && rate_r[lpa_pkg::RATE_W-1] &&
                      (acc_r < lin_w);
  assign rem_shift  = {rem_r, dvd_r[DVD_W-1]};
  assign rem_sub    = rem_shift - {1'b0, len_r};
  assign rem_w      = WW'($signed({1'b0, rem_r}));
  assign fin_w      = !neg_r ? (lin_w + rem_w) :
                      (rem_r == '0) ? lin_w : (lout_w - rem_w);
  assign pos_w      = WW'(pos_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpa_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_data.kind == lpa_pkg::KIND_SEEK || !tick_run) begin
            state_nxt = lpa_pkg::ST_DONE;
          end else begin
            state_nxt = lpa_pkg::ST_ADD;
          end
        end
      end
      lpa_pkg::ST_ADD:  state_nxt = lpa_pkg::ST_WRAP;
      lpa_pkg::ST_WRAP: state_nxt = (wrap_fwd || wrap_rev) ? lpa_pkg::ST_DIV : lpa_pkg::ST_DONE;
      lpa_pkg::ST_DIV:  state_nxt = (cnt_r == '0) ? lpa_pkg::ST_FIN : lpa_pkg::ST_DIV;
      lpa_pkg::ST_FIN:  state_nxt = lpa_pkg::ST_DONE;
      lpa_pkg::ST_DONE: state_nxt = out_free ? lpa_pkg::ST_IDLE : lpa_pkg::ST_DONE;
      default:          state_nxt = lpa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    loaded_nxt   = loaded_r;
    playing_nxt  = playing_r;
    rate_nxt     = rate_r;
    loop_en_nxt  = loop_en_r;
    loop_in_nxt  = loop_in_r;
    loop_out_nxt = loop_out_r;
    if (cfg_we) begin
      case (cfg_index)
        lpa_pkg::CFG_TRACK_LOADED:  loaded_nxt   = cfg_data[0];
        lpa_pkg::CFG_PLAYING:       playing_nxt  = cfg_data[0];
        lpa_pkg::CFG_PLAYBACK_RATE: rate_nxt     = cfg_data[lpa_pkg::RATE_W-1:0];
        lpa_pkg::CFG_LOOP_ENABLE:   loop_en_nxt  = cfg_data[0];
        lpa_pkg::CFG_LOOP_IN:       loop_in_nxt  = cfg_data;
        lpa_pkg::CFG_LOOP_OUT:      loop_out_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_nxt       = pos_r;
    pend_nxt      = pend_r;
    pend_pos_nxt  = pend_pos_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    adv_nxt       = adv_r;
    wrap_nxt      = wrap_r;
    sat_nxt       = sat_r;
    neg_nxt       = neg_r;
    dvd_nxt       = dvd_r;
    len_nxt       = len_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      lpa_pkg::ST_IDLE: begin
        if (in_fire) begin
          adv_nxt  = 1'b0;
          wrap_nxt = 1'b0;
          sat_nxt  = 1'b0;
          prod_nxt = prod_now;
          if (in_data.kind == lpa_pkg::KIND_SEEK) begin
            pend_nxt     = 1'b1;
            pend_pos_nxt = seek_clamp[P-1:0];
          end else if (pend_r) begin
            pend_nxt = 1'b0;
            pos_nxt  = pend_pos_r;
          end
        end
      end
      lpa_pkg::ST_ADD: begin
        adv_nxt = 1'b1;
        if (sum_w > POS_MAX_W) begin
          acc_nxt = POS_MAX_W;
          sat_nxt = 1'b1;
        end else if (sum_w < POS_MIN_W) begin
          acc_nxt = POS_MIN_W;
          sat_nxt = 1'b1;
        end else begin
          acc_nxt = sum_w;
        end
      end
      lpa_pkg::ST_WRAP: begin
        len_nxt = LEN_W'(lout_w - lin_w);
        rem_nxt = '0;
        cnt_nxt = CNT_LAST;
        neg_nxt = wrap_rev;
        dvd_nxt = wrap_rev ? diff_rev[DVD_W-1:0] : diff_fwd[DVD_W-1:0];
        if (wrap_fwd || wrap_rev) begin
          wrap_nxt = 1'b1;
        end else begin
          pos_nxt = acc_r[P-1:0];
        end
      end
      lpa_pkg::ST_DIV: begin
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        rem_nxt = (rem_shift >= {1'b0, len_r}) ? rem_sub[LEN_W-1:0] : rem_shift[LEN_W-1:0];
      end
      lpa_pkg::ST_FIN: begin
        pos_nxt = fin_w[P-1:0];
      end
      lpa_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.position  = pos_w[lpa_pkg::FIELD_POS_W-1:0];
          out_data_nxt.advanced  = adv_r;
          out_data_nxt.wrapped   = wrap_r;
          out_data_nxt.saturated = sat_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpa_pkg::ST_IDLE;
      loaded_r    <= 1'b0;
      playing_r   <= 1'b0;
      rate_r      <= lpa_pkg::RATE_RESET;
      loop_en_r   <= 1'b0;
      loop_in_r   <= '0;
      loop_out_r  <= '0;
      pos_r       <= '0;
      pend_r      <= 1'b0;
      pend_pos_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      playing_r   <= playing_nxt;
      rate_r      <= rate_nxt;
      loop_en_r   <= loop_en_nxt;
      loop_in_r   <= loop_in_nxt;
      loop_out_r  <= loop_out_nxt;
      pos_r       <= pos_nxt;
      pend_r      <= pend_nxt;
      pend_pos_r  <= pend_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    adv_r      <= adv_nxt;
    wrap_r     <= wrap_nxt;
    sat_r      <= sat_nxt;
    neg_r      <= neg_nxt;
    dvd_r      <= dvd_nxt;
    len_r      <= len_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
